>>> rtl/sbpr_pkg.sv
// ----------------------------------------------------------------------------
// sbpr_pkg
// shared constants and types of the spectrum bar page renderer
// ----------------------------------------------------------------------------
package sbpr_pkg;

    localparam int MAX_BANDS_DEF       = 128;
    localparam int GRAPH_HEIGHT_DEF    = 48;
    localparam int DISPLAY_COLUMNS_DEF = 128;

    localparam int CNT_W   = 8;
    localparam int COL_W   = 8;
    localparam int QUOT_W  = 7;
    localparam int PAGE_W  = 3;
    localparam int BYTE_W  = 8;

    localparam logic [CNT_W-1:0] BAND_COUNT_RST = 8'd16;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_EMIT    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [PAGE_W-1:0] FIRST_PAGE = 3'd2;
    localparam logic [PAGE_W-1:0] PAGE_COUNT = 3'd6;
    localparam logic [COL_W-1:0]  CMD_SLOTS  = 8'd3;

    localparam logic [BYTE_W-1:0] CMD_PAGE_SEL = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_COL_LOW  = 8'h00;
    localparam logic [BYTE_W-1:0] PAGE_MASK    = 8'h0F;

    typedef struct packed {
        logic             start;
        logic [COL_W-1:0] col;
        logic [CNT_W-1:0] cnt;
    } t_div_req;

endpackage

>>> rtl/spectrum_bar_page_renderer_unit.sv
// ----------------------------------------------------------------------------
// spectrum_bar_page_renderer_unit
// renders a bar graph frame for a page-addressed monochrome display
//
// channel   direction  handshake                 payload
// request   in         i_in_valid / o_in_stall   i_req_type i_band_index i_bar_height
// result    out        o_out_valid / i_out_stall o_out_byte o_is_command o_frame_last
// config    in         i_cfg_we                  i_cfg_wdata (band count)
//
// height write and restart complete when accepted, a command byte goes straight to the output state
// a data byte passes in turn: col * count is registered, scaled to a band,
// read from the table, made into the pixel byte and loaded into the output register
// reset clears the valid bits of the height table at once, no clearing pass
// a stalled result holds in the output register; a further emit waits for it
// ----------------------------------------------------------------------------
module spectrum_bar_page_renderer_unit #(
    parameter int MAX_BANDS       = sbpr_pkg::MAX_BANDS_DEF,
    parameter int GRAPH_HEIGHT    = sbpr_pkg::GRAPH_HEIGHT_DEF,
    parameter int DISPLAY_COLUMNS = sbpr_pkg::DISPLAY_COLUMNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [6:0] i_band_index,
    input  logic [7:0] i_bar_height,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_command,
    output logic       o_frame_last,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    localparam int AW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam logic [sbpr_pkg::CNT_W-1:0] MAX_CNT = sbpr_pkg::CNT_W'(MAX_BANDS);
    localparam logic [sbpr_pkg::COL_W-1:0] SLOTS_TOTAL =
        sbpr_pkg::COL_W'(3 + DISPLAY_COLUMNS);
    localparam logic [7:0] GH = 8'(GRAPH_HEIGHT);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_PIX  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [sbpr_pkg::PAGE_W-1:0] r_page;
    logic [sbpr_pkg::COL_W-1:0]  r_slot;
    logic [sbpr_pkg::CNT_W-1:0]  r_band_count;
    logic [MAX_BANDS-1:0]        r_valid;
    logic                        r_hit;
    logic [AW-1:0]               r_band;
    logic [sbpr_pkg::PAGE_W-1:0] r_page_rel;
    logic [7:0]                  r_res_byte;
    logic                        r_res_cmd;
    logic                        r_res_last;
    logic                        r_out_valid;
    logic [7:0]                  r_out_byte;
    logic                        r_out_cmd;
    logic                        r_out_last;

    logic                        accept;
    logic                        do_write;
    logic                        do_emit;
    logic                        out_free;
    logic [sbpr_pkg::PAGE_W-1:0] cur_page;
    logic [sbpr_pkg::COL_W-1:0]  cur_slot;
    logic [sbpr_pkg::PAGE_W-1:0] nxt_page;
    logic [sbpr_pkg::COL_W-1:0]  nxt_slot;
    logic                        nxt_last;
    logic                        slot_cmd;
    logic [7:0]                  cmd_byte;
    logic [sbpr_pkg::CNT_W-1:0]  cnt_sat;
    logic [AW-1:0]               band_clamped;
    logic [7:0]                  height;
    logic [7:0]                  top_row;
    logic [7:0]                  pix;
    logic [7:0]                  rdata;
    logic                        div_done;
    logic [sbpr_pkg::QUOT_W-1:0] div_quot;
    sbpr_pkg::t_div_req          div_req;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign do_write = accept && (i_req_type == sbpr_pkg::REQ_WRITE)
                      && ({1'b0, i_band_index} < 8'(MAX_BANDS));
    assign do_emit  = accept && (i_req_type == sbpr_pkg::REQ_EMIT)
                      && (r_band_count != '0);
    assign out_free = !r_out_valid || !i_out_stall;

    assign cnt_sat = (r_band_count > MAX_CNT) ? MAX_CNT : r_band_count;

    // frame position and the byte it selects
    always_comb begin
        if (r_page >= sbpr_pkg::PAGE_COUNT || r_slot >= SLOTS_TOTAL) begin
            cur_page = '0;
            cur_slot = '0;
        end else begin
            cur_page = r_page;
            cur_slot = r_slot;
        end
        slot_cmd = (cur_slot < sbpr_pkg::CMD_SLOTS);
        case (cur_slot)
            8'd0:    cmd_byte = sbpr_pkg::CMD_PAGE_SEL
                                | (8'(cur_page + sbpr_pkg::FIRST_PAGE) & sbpr_pkg::PAGE_MASK);
            8'd1:    cmd_byte = sbpr_pkg::CMD_COL_HIGH;
            default: cmd_byte = sbpr_pkg::CMD_COL_LOW;
        endcase
        nxt_slot = cur_slot + 1'b1;
        nxt_page = cur_page;
        nxt_last = 1'b0;
        if (nxt_slot >= SLOTS_TOTAL) begin
            nxt_slot = '0;
            nxt_page = cur_page + 1'b1;
            if (nxt_page >= sbpr_pkg::PAGE_COUNT) begin
                nxt_page = '0;
                nxt_last = 1'b1;
            end
        end
    end

    assign div_req.start = do_emit && !slot_cmd;
    assign div_req.col   = cur_slot - sbpr_pkg::CMD_SLOTS;
    assign div_req.cnt   = cnt_sat;

    sbpr_band_div #(
        .DISPLAY_COLUMNS(DISPLAY_COLUMNS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    assign band_clamped = (8'(div_quot) >= 8'(MAX_BANDS)) ? AW'(MAX_BANDS - 1)
                                                          : AW'(div_quot);

    sbpr_ram #(
        .WIDTH(8),
        .DEPTH(MAX_BANDS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (do_write),
        .i_waddr(i_band_index[AW-1:0]),
        .i_wdata(i_bar_height),
        .i_re   (r_state == S_RD),
        .i_raddr(r_band),
        .o_rdata(rdata)
    );

    // pixel byte of one column on one page
    always_comb begin
        height  = r_hit ? rdata : 8'd0;
        top_row = (height >= GH) ? 8'd0 : (GH - height);
        for (int b = 0; b < 8; b++) begin
            pix[b] = ({2'b00, r_page_rel, 3'(b)} >= top_row);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (do_emit) begin
                    n_state = slot_cmd ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD:    n_state = S_PIX;
            S_PIX:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_page       <= '0;
            r_slot       <= '0;
            r_band_count <= sbpr_pkg::BAND_COUNT_RST;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_band_count <= i_cfg_wdata;
            end
            if (do_write) begin
                r_valid[i_band_index[AW-1:0]] <= 1'b1;
            end
            if (accept && i_req_type == sbpr_pkg::REQ_RESTART) begin
                r_page <= '0;
                r_slot <= '0;
            end else if (do_emit) begin
                r_page <= nxt_page;
                r_slot <= nxt_slot;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_res_byte <= cmd_byte;
            r_res_cmd  <= slot_cmd;
            r_res_last <= nxt_last;
            r_page_rel <= cur_page;
        end
        if (r_state == S_DIV && div_done) begin
            r_band <= band_clamped;
        end
        if (r_state == S_RD) begin
            r_hit <= r_valid[r_band];
        end
        if (r_state == S_PIX) begin
            r_res_byte <= pix;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_byte <= r_res_byte;
            r_out_cmd  <= r_res_cmd;
            r_out_last <= r_res_last;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_command = r_out_cmd;
    assign o_frame_last = r_out_last;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("band divider finished outside its wait state");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result left its wait state while the output was stalled");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_last && r_out_cmd))
        else $error("frame end marked on a command byte");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot < SLOTS_TOTAL) && (r_page < sbpr_pkg::PAGE_COUNT))
        else $error("frame position out of range");

endmodule

>>> rtl/sbpr_ram.sv
// ----------------------------------------------------------------------------
// sbpr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sbpr_band_div.sv
// ----------------------------------------------------------------------------
// sbpr_band_div
// maps a column to its band: (col * count) / columns by a constant reciprocal
// ----------------------------------------------------------------------------
module sbpr_band_div #(
    parameter int DISPLAY_COLUMNS = sbpr_pkg::DISPLAY_COLUMNS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbpr_pkg::t_div_req          i_req,
    output logic                        o_done,
    output logic [sbpr_pkg::QUOT_W-1:0] o_quot
);

    localparam int CW    = (DISPLAY_COLUMNS > 1) ? $clog2(DISPLAY_COLUMNS) : 1;
    localparam int PW    = sbpr_pkg::COL_W + sbpr_pkg::CNT_W;
    localparam int RW    = PW + 2;
    localparam int SHIFT = PW + CW;
    localparam int MW    = PW + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((longint'(1) << SHIFT) + longint'(DISPLAY_COLUMNS) - longint'(1))
            / longint'(DISPLAY_COLUMNS));

    logic [PW-1:0] prod;
    logic [PW-1:0] r_prod;
    logic [MW-1:0] scaled;
    logic          r_done;

    assign prod   = PW'(i_req.col) * PW'(i_req.cnt);
    assign scaled = MW'(r_prod) * MW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= prod;
        end
    end

    assign o_done = r_done;
    assign o_quot = scaled[SHIFT +: sbpr_pkg::QUOT_W];

endmodule
